@@ rtl/mcpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared types and constants for the multi-channel PWM generator.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

    localparam int unsigned PHASE_W  = 9;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned STEP_W   = 7;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 7;
    localparam int unsigned PINS_W   = 16;

    localparam logic [PHASE_W-1:0] PERIOD_UNITS = 9'd200;
    localparam logic [PHASE_W-1:0] LAST_PHASE   = 9'd199;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_READ  = 3'd2,
        ACT_START = 3'd3,
        ACT_STOP  = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TICK   = 4'b0010,
        S_RELOAD = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    // Control from the sequencer to the duty store
    typedef struct packed {
        logic pend_we;
        logic tick_en;
        logic reload_en;
    } t_duty_ctrl;

endpackage

@@ rtl/multi_channel_pwm_generator_unit.sv @@
// ----------------------------------------------------------------------------
// multi_channel_pwm_generator_unit
// Software-style PWM over a 200-unit period with shadow duty registers.
// ----------------------------------------------------------------------------
// One transaction is one action: tick, pending-duty write, active-duty read,
// start or stop; each gives exactly one result. Write, read, stop, an idle
// tick and unused codes pass from the idle state through the done state into
// the output register. A tick that advances the phase and any reload
// (start, or a tick at the end of the period) first sweep every channel in
// the tick or reload state before the done state: one comparator walks the
// channels one per cycle. The input is not ready while an action is in
// progress; a finished result sits in an output register, so the next
// transaction can be taken while it waits. Configuration writes are
// taken at any time and should be made while the block is idle.
module multi_channel_pwm_generator_unit #(
    parameter int unsigned CHANNELS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mcpwm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mcpwm_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_action,
    input  logic [3:0]                          i_channel,
    input  logic [7:0]                          i_duty_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mcpwm_pkg::PINS_W-1:0]        o_pin_levels,
    output logic [7:0]                          o_read_duty,
    output logic                                o_status
);

    localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned NW = ($clog2(CHANNELS + 1) > mcpwm_pkg::COUNT_W) ?
                                 $clog2(CHANNELS + 1) : mcpwm_pkg::COUNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

    mcpwm_pkg::t_state r_state, n_state;
    logic [IW-1:0]                       r_idx, n_idx;
    logic [mcpwm_pkg::PHASE_W-1:0]       r_phase, n_phase;
    logic [CHANNELS-1:0]                 r_chan_on, n_chan_on;
    logic                                r_running, n_running;
    logic [mcpwm_pkg::DUTY_W-1:0]        r_rd, n_rd;
    logic                                r_stat, n_stat;
    logic                                r_out_valid, n_out_valid;
    logic [mcpwm_pkg::PINS_W-1:0]        r_pins, n_pins;
    logic [mcpwm_pkg::DUTY_W-1:0]        r_out_rd, n_out_rd;
    logic                                r_out_stat, n_out_stat;
    logic [mcpwm_pkg::STEP_W-1:0]        r_step;
    logic [mcpwm_pkg::COUNT_W-1:0]       r_count;

    mcpwm_pkg::t_duty_ctrl               w_ctrl;
    logic [NW-1:0]                       w_used;
    logic [IW-1:0]                       w_chn_idx;
    logic [IW-1:0]                       w_addr;
    logic                                w_chn_ok;
    logic                                w_last;
    logic [mcpwm_pkg::DUTY_W-1:0]        w_rd_data;
    logic                                w_bit_next;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == mcpwm_pkg::S_IDLE);

    assign w_used    = (NW'(r_count) < NW'(CHANNELS)) ? NW'(r_count) : NW'(CHANNELS);
    assign w_chn_idx = IW'(i_channel);
    assign w_chn_ok  = (NW'(i_channel) < w_used);
    assign w_addr    = (r_state == mcpwm_pkg::S_IDLE) ? w_chn_idx : r_idx;
    assign w_last    = (r_idx == LAST_IDX);

    mcpwm_duty_store #(
        .CHANNELS (CHANNELS),
        .IW       (IW),
        .NW       (NW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_addr     (w_addr),
        .i_wr_addr  (w_chn_idx),
        .i_wr_data  (i_duty_value),
        .i_phase    (r_phase),
        .i_used     (w_used),
        .i_cur_on   (r_chan_on[r_idx]),
        .o_rd_data  (w_rd_data),
        .o_bit_next (w_bit_next)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_chan_on   = r_chan_on;
        n_running   = r_running;
        n_rd        = r_rd;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_pins      = r_pins;
        n_out_rd    = r_out_rd;
        n_out_stat  = r_out_stat;
        w_ctrl      = '0;

        case (r_state)
            mcpwm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_rd    = '0;
                    n_stat  = 1'b0;
                    n_state = mcpwm_pkg::S_DONE;
                    case (mcpwm_pkg::t_action'(i_action))
                        mcpwm_pkg::ACT_TICK: begin
                            if (r_running) begin
                                if (r_phase < mcpwm_pkg::LAST_PHASE) begin
                                    n_phase = r_phase + mcpwm_pkg::PHASE_W'(r_step);
                                    n_state = mcpwm_pkg::S_TICK;
                                end else begin
                                    n_phase = '0;
                                    n_state = mcpwm_pkg::S_RELOAD;
                                end
                            end
                        end
                        mcpwm_pkg::ACT_WRITE: begin
                            if (w_chn_ok) begin
                                w_ctrl.pend_we = 1'b1;
                            end else begin
                                n_stat = 1'b1;
                            end
                        end
                        mcpwm_pkg::ACT_READ: begin
                            if (w_chn_ok) begin
                                n_rd = w_rd_data;
                            end else begin
                                n_stat = 1'b1;
                            end
                        end
                        mcpwm_pkg::ACT_START: begin
                            n_phase   = '0;
                            n_running = 1'b1;
                            n_state   = mcpwm_pkg::S_RELOAD;
                        end
                        mcpwm_pkg::ACT_STOP: begin
                            n_chan_on = '0;
                            n_running = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mcpwm_pkg::S_TICK, mcpwm_pkg::S_RELOAD: begin
                w_ctrl.tick_en   = (r_state == mcpwm_pkg::S_TICK);
                w_ctrl.reload_en = (r_state == mcpwm_pkg::S_RELOAD);
                n_chan_on[r_idx] = w_bit_next;
                if (w_last) begin
                    n_idx   = '0;
                    n_state = mcpwm_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            mcpwm_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_pins      = mcpwm_pkg::PINS_W'(r_chan_on);
                    n_out_rd    = r_rd;
                    n_out_stat  = r_stat;
                    n_state     = mcpwm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mcpwm_pkg::S_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcpwm_pkg::S_IDLE;
            r_idx       <= '0;
            r_phase     <= mcpwm_pkg::PERIOD_UNITS;
            r_chan_on   <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= mcpwm_pkg::STEP_W'(1);
            r_count     <= mcpwm_pkg::COUNT_W'(16);
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_phase     <= n_phase;
            r_chan_on   <= n_chan_on;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mcpwm_pkg::CFG_STEP:  r_step  <= i_cfg_data;
                    mcpwm_pkg::CFG_COUNT: r_count <= i_cfg_data[mcpwm_pkg::COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd       <= n_rd;
        r_stat     <= n_stat;
        r_pins     <= n_pins;
        r_out_rd   <= n_out_rd;
        r_out_stat <= n_out_stat;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pin_levels = r_pins;
    assign o_read_duty  = r_out_rd;
    assign o_status     = r_out_stat;

    // sweep index parks at zero outside a sweep
    a_idx_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcpwm_pkg::S_IDLE || r_state == mcpwm_pkg::S_DONE) |-> (r_idx == '0))
        else $error("sweep index not parked");

    // a reload always finishes with the phase at zero
    a_reload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcpwm_pkg::S_RELOAD && w_last) |=> (r_phase == '0))
        else $error("phase not cleared by reload");

    // no channel is on while stopped
    a_stopped_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_running && r_state == mcpwm_pkg::S_IDLE) |-> (r_chan_on == '0))
        else $error("channel on while stopped");

endmodule

@@ rtl/mcpwm_duty_store.sv @@
// ----------------------------------------------------------------------------
// mcpwm_duty_store
// Pending and active duty registers with the shared channel comparator.
// ----------------------------------------------------------------------------
module mcpwm_duty_store #(
    parameter int unsigned CHANNELS = 16,
    parameter int unsigned IW       = 4,
    parameter int unsigned NW       = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mcpwm_pkg::t_duty_ctrl             i_ctrl,
    input  logic [IW-1:0]                     i_addr,
    input  logic [IW-1:0]                     i_wr_addr,
    input  logic [mcpwm_pkg::DUTY_W-1:0]      i_wr_data,
    input  logic [mcpwm_pkg::PHASE_W-1:0]     i_phase,
    input  logic [NW-1:0]                     i_used,
    input  logic                              i_cur_on,
    output logic [mcpwm_pkg::DUTY_W-1:0]      o_rd_data,
    output logic                              o_bit_next
);

    logic [mcpwm_pkg::DUTY_W-1:0] r_active  [CHANNELS];
    logic [mcpwm_pkg::DUTY_W-1:0] r_pending [CHANNELS];

    logic [mcpwm_pkg::DUTY_W-1:0]  w_act;
    logic [mcpwm_pkg::DUTY_W-1:0]  w_pend;
    logic [mcpwm_pkg::PHASE_W-1:0] w_cmp_a;
    logic [mcpwm_pkg::PHASE_W-1:0] w_cmp_b;
    logic                          w_le;
    logic                          w_in_use;

    assign w_act  = r_active[i_addr];
    assign w_pend = r_pending[i_addr];

    // single comparator: duty <= phase on a tick, used <= index on a reload
    always_comb begin
        if (i_ctrl.tick_en) begin
            w_cmp_a = mcpwm_pkg::PHASE_W'(w_act);
            w_cmp_b = i_phase;
        end else begin
            w_cmp_a = mcpwm_pkg::PHASE_W'(i_used);
            w_cmp_b = mcpwm_pkg::PHASE_W'(i_addr);
        end
    end

    assign w_le     = (w_cmp_a <= w_cmp_b);
    assign w_in_use = !w_le;

    always_comb begin
        if (i_ctrl.tick_en) begin
            o_bit_next = i_cur_on && !w_le;
        end else begin
            o_bit_next = w_in_use && (w_pend != '0);
        end
    end

    assign o_rd_data = w_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_active[i]  <= '0;
                r_pending[i] <= '0;
            end
        end else begin
            if (i_ctrl.pend_we) begin
                r_pending[i_wr_addr] <= i_wr_data;
            end
            if (i_ctrl.reload_en && w_in_use) begin
                r_active[i_addr] <= w_pend;
            end
        end
    end

endmodule
